// ----- src/assert_macros.svh -----
// Assertion macros used by the search block's match core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define FOES_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define FOES_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/foes_pkg.sv -----
// Shared types and constants of the first-occurrence element search.
`timescale 1ns / 1ps

package foes_pkg;

   localparam int VALUE_W     = 64;
   localparam int INDEX_W     = 5;
   localparam int EB_W        = 4;
   localparam int NL_W        = 6;
   localparam int CLAMP_W     = NL_W + 1;
   localparam int POS_W       = 32;
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_ADDR_W  = 1;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 32;

   localparam logic [POS_W-1:0] COUNTER_MAX = '1;
   localparam logic [EB_W-1:0]  MAX_WIDTH_BYTES = 4'd8;

   typedef enum logic {
      KIND_LOAD     = 1'b0,
      KIND_HAYSTACK = 1'b1
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WIDTH_BYTES   = 1'b0,
      CSR_NEEDLE_LENGTH = 1'b1
   } csr_addr_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   element_value;
      logic [INDEX_W-1:0]   needle_index;
      logic                 is_last;
   } item_type;

   typedef struct packed {
      logic [EB_W-1:0] width_bytes;
      logic [NL_W-1:0] needle_length;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic step;
   } ctl_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] match_position;
   } result_type;

endpackage

// ----- src/foes_needle_bank.sv -----
// Needle element registers and one masked equality comparator per slot.
`timescale 1ns / 1ps

module foes_needle_bank #(
   parameter int MAX_NEEDLE   = 32,
   parameter int ELEMENT_BITS = 64
) (
   input  logic                 clock,
   input  foes_pkg::ctl_type    ctl,
   input  foes_pkg::item_type   item,
   input  foes_pkg::cfg_type    cfg,
   output logic [MAX_NEEDLE-1:0] eq
);

   logic [foes_pkg::EB_W-1:0]  bytes_eff;
   logic [ELEMENT_BITS-1:0]    cmask;
   logic [ELEMENT_BITS-1:0]    needle_ff [MAX_NEEDLE];

   // Zero acts as one byte, anything above eight as eight.
   always_comb begin
      if (cfg.width_bytes == '0) begin
         bytes_eff = foes_pkg::EB_W'(1);
      end else if (cfg.width_bytes > foes_pkg::MAX_WIDTH_BYTES) begin
         bytes_eff = foes_pkg::MAX_WIDTH_BYTES;
      end else begin
         bytes_eff = cfg.width_bytes;
      end
   end

   for (genvar b = 0; b < ELEMENT_BITS; b++) begin : g_mask
      assign cmask[b] = (foes_pkg::EB_W'(b / 8) < bytes_eff);
   end

   // A load beat writes the one slot that its index names.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NEEDLE; i++) begin
         if (ctl.load && ({1'b0, item.needle_index} == (foes_pkg::INDEX_W + 1)'(i))) begin
            needle_ff[i] <= item.element_value[ELEMENT_BITS-1:0];
         end
      end
   end

   for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_slot
      assign eq[i] = ((item.element_value[ELEMENT_BITS-1:0] ^ needle_ff[i]) & cmask) == '0;
   end

endmodule

// ----- src/foes_match_core.sv -----
// Shift-and partial match vector, element counter and result decision.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module foes_match_core #(
   parameter int MAX_NEEDLE = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  foes_pkg::ctl_type      ctl,
   input  foes_pkg::item_type     item,
   input  foes_pkg::cfg_type      cfg,
   input  logic [MAX_NEEDLE-1:0]  eq,
   output foes_pkg::result_type   res
);

   logic [foes_pkg::CLAMP_W-1:0] len_eff;
   logic [MAX_NEEDLE-1:0]        len_mask;
   logic [MAX_NEEDLE-1:0]        top_mask;
   logic [MAX_NEEDLE-1:0]        pm_next;
   logic                         full_match;
   logic                         hit;
   logic [foes_pkg::POS_W-1:0]   start_pos;

   logic [MAX_NEEDLE-1:0]        pm_ff, pm_in;
   logic [foes_pkg::POS_W-1:0]   counter_ff, counter_in;
   logic                         reported_ff, reported_in;

   // Needle length clamped to the range one to MAX_NEEDLE.
   always_comb begin
      if (cfg.needle_length == '0) begin
         len_eff = foes_pkg::CLAMP_W'(1);
      end else if ({1'b0, cfg.needle_length} > foes_pkg::CLAMP_W'(MAX_NEEDLE)) begin
         len_eff = foes_pkg::CLAMP_W'(MAX_NEEDLE);
      end else begin
         len_eff = {1'b0, cfg.needle_length};
      end
   end

   for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_len
      assign len_mask[i] = (len_eff > foes_pkg::CLAMP_W'(i));
      assign top_mask[i] = (len_eff == foes_pkg::CLAMP_W'(i + 1));
   end

   assign pm_next    = {pm_ff[MAX_NEEDLE-2:0], 1'b1} & eq & len_mask;
   assign full_match = |(pm_next & top_mask);
   assign hit        = !reported_ff && (counter_ff != foes_pkg::COUNTER_MAX) && full_match;
   assign start_pos  = counter_ff - foes_pkg::POS_W'(len_eff) + foes_pkg::POS_W'(1);

   always_comb begin
      res.valid          = ctl.step && (hit || (item.is_last && !reported_ff));
      res.found          = hit;
      res.match_position = hit ? start_pos : '0;
   end

   always_comb begin
      pm_in       = pm_ff;
      counter_in  = counter_ff;
      reported_in = reported_ff;
      if (ctl.step) begin
         if (item.is_last) begin
            pm_in       = '0;
            counter_in  = '0;
            reported_in = 1'b0;
         end else begin
            pm_in       = pm_next;
            reported_in = reported_ff || hit;
            if (counter_ff != foes_pkg::COUNTER_MAX) begin
               counter_in = counter_ff + foes_pkg::POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff       <= '0;
         counter_ff  <= '0;
         reported_ff <= 1'b0;
      end else begin
         pm_ff       <= pm_in;
         counter_ff  <= counter_in;
         reported_ff <= reported_in;
      end
   end

   `FOES_ASSERT_SAME(a_single_report, clock, reset, reported_ff, !(res.valid && res.found), "second match reported in one search")
   `FOES_ASSERT_NEXT(a_report_marks, clock, reset, ctl.step && hit && !item.is_last, reported_ff, "match not remembered as reported")
   `FOES_ASSERT_NEXT(a_last_clears, clock, reset, ctl.step && item.is_last, (pm_ff == '0) && (counter_ff == '0) && !reported_ff, "search state not cleared after last beat")
   `FOES_ASSERT_SAME(a_result_from_step, clock, reset, res.valid, ctl.step && !ctl.load, "result raised without a haystack beat")

endmodule

// ----- src/first_occurrence_element_search.sv -----
// Top level of the first-occurrence element search: ports, buffers and configuration.
`timescale 1ns / 1ps
// Streamed exact search for a needle of up to MAX_NEEDLE elements in a haystack.
// The req channel carries one beat per element. A beat with tuser low loads the
// needle slot given in tdata; a beat with tuser high is a haystack element, and
// tlast marks the final element of a search. The csr port sets the element size
// in bytes and the needle length. The user must write it only while the block is
// idle; the block itself does not enforce this. For each search the rsp channel
// delivers one beat: found with the start index of the first occurrence, or, on
// the final element, not found with position 0. Beats are taken at one per cycle
// while the receiver does not stall. An accepted beat is held in the input
// register, is processed by the comparators and the shift-and update, and its
// result is captured in the output register, which drives rsp_tvalid. The
// shift-and vector closes its loop through the single register pm_ff, which sets
// the one-beat-per-cycle rate.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more beat; req_tready then drops until the result
// is taken. Reset clears the search state and sets the element size and needle
// length to one; needle slots hold nothing defined until they are loaded.

module first_occurrence_element_search #(
   parameter int MAX_NEEDLE   = 32,
   parameter int ELEMENT_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [foes_pkg::REQ_TDATA_W-1:0]    req_tdata,  // element_value, needle_index, zero fill
   input  logic                                req_tuser,  // kind
   input  logic                                req_tlast,  // is_last
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [foes_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // match_position
   output logic                                rsp_tuser,  // found
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [foes_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [foes_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_LO = foes_pkg::VALUE_W;
   localparam int IDX_HI = foes_pkg::VALUE_W + foes_pkg::INDEX_W - 1;

   logic                  advance;
   logic                  req_accept;
   foes_pkg::ctl_type     ctl;
   foes_pkg::result_type  res;
   logic [MAX_NEEDLE-1:0] eq;

   logic                  in_valid_ff, in_valid_in;
   foes_pkg::item_type    item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;
   logic [foes_pkg::POS_W-1:0] rsp_pos_ff;
   foes_pkg::cfg_type     cfg_ff, cfg_in;

   // The processing stage moves whenever the output register is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign ctl.load = in_valid_ff && advance && (item_ff.kind == foes_pkg::KIND_LOAD);
   assign ctl.step = in_valid_ff && advance && (item_ff.kind == foes_pkg::KIND_HAYSTACK);

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = res.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Register writes; the two indexes cover the whole address space.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (foes_pkg::csr_addr_type'(csr_addr))
            foes_pkg::CSR_WIDTH_BYTES: begin
               cfg_in.width_bytes = csr_wdata[foes_pkg::EB_W-1:0];
            end
            foes_pkg::CSR_NEEDLE_LENGTH: begin
               cfg_in.needle_length = csr_wdata[foes_pkg::NL_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.width_bytes   <= foes_pkg::EB_W'(1);
         cfg_ff.needle_length <= foes_pkg::NL_W'(1);
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind          <= foes_pkg::kind_type'(req_tuser);
         item_ff.element_value <= req_tdata[foes_pkg::VALUE_W-1:0];
         item_ff.needle_index  <= req_tdata[IDX_HI:IDX_LO];
         item_ff.is_last       <= req_tlast;
      end
      if (advance && res.valid) begin
         rsp_found_ff <= res.found;
         rsp_pos_ff   <= res.match_position;
      end
   end

   foes_needle_bank #(
      .MAX_NEEDLE   (MAX_NEEDLE),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_bank (
      .clock (clock),
      .ctl   (ctl),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .eq    (eq)
   );

   foes_match_core #(
      .MAX_NEEDLE (MAX_NEEDLE)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .eq    (eq),
      .res   (res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule
